### hdl/bhf_pkg.sv
// Shared types, constants and saturation helpers for the biquad highpass filter.
package bhf_pkg;

    // Fixed datapath widths
    localparam int ACC_BITS  = 48;
    localparam int FB_BITS   = 32;
    localparam int NF_BITS   = ACC_BITS + 2;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FEED0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEED1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEED2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACK2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd5;

    // Operand pair on the shared multiplier
    typedef enum logic [2:0] {
        MUL_F0X  = 3'd0,
        MUL_F1X  = 3'd1,
        MUL_F2X  = 3'd2,
        MUL_B1FB = 3'd3,
        MUL_B2FB = 3'd4,
        MUL_GAIN = 3'd5
    } t_mul_sel;

    // Per-cycle controls from the sequencer to the datapath
    typedef struct packed {
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ld_acc;   // acc    = sat(d1 + prod)
        logic     ld_fb;    // fb     = sat(round(acc))
        logic     ld_nf;    // nf     = prod (feed1 term)
        logic     ld_ns;    // ns     = prod (feed2 term)
        logic     add_d2;   // nf     = nf + d2
        logic     ld_d1;    // d1     = sat(nf - prod)
        logic     ld_d2;    // d2     = sat(ns - prod)
        logic     ld_out;   // output = sat(round(prod))
    } t_ctrl;

    localparam logic signed [63:0] ACC_MAX = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] ACC_MIN = -ACC_MAX - 64'sd1;
    localparam logic signed [63:0] FB_MAX  = (64'sd1 <<< (FB_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] FB_MIN  = -FB_MAX - 64'sd1;

    // Clamp to the accumulator range
    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [63:0] v);
        logic signed [63:0] c;
        if (v > ACC_MAX) c = ACC_MAX;
        else if (v < ACC_MIN) c = ACC_MIN;
        else c = v;
        return c[ACC_BITS-1:0];
    endfunction

    // Clamp to the feedback range
    function automatic logic signed [FB_BITS-1:0] sat_fb(input logic signed [63:0] v);
        logic signed [63:0] c;
        if (v > FB_MAX) c = FB_MAX;
        else if (v < FB_MIN) c = FB_MIN;
        else c = v;
        return c[FB_BITS-1:0];
    endfunction

endpackage

### hdl/bhf_mult.sv
// Shared signed multiplier with a registered product.
module bhf_mult #(
    parameter int A_W = 32,
    parameter int B_W = 18
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [B_W-1:0]      i_b,
    output logic signed [A_W+B_W-1:0]  o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;

    // One product per enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

### hdl/bhf_seq.sv
// Sequencer that steps one sample through the shared multiplier and adder.
module bhf_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_busy,
    output logic              o_idle,
    output bhf_pkg::t_ctrl    o_ctrl
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MF0   = 8'b0000_0010,
        ST_ACC   = 8'b0000_0100,
        ST_FB    = 8'b0000_1000,
        ST_ADDD2 = 8'b0001_0000,
        ST_UPD1  = 8'b0010_0000,
        ST_UPD2  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    bhf_pkg::t_ctrl ctrl;

    // Next state and control decode
    always_comb begin
        ctrl    = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_MF0;
            end
            ST_MF0: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = bhf_pkg::MUL_F0X;
                n_state      = ST_ACC;
            end
            ST_ACC: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = bhf_pkg::MUL_F1X;
                ctrl.ld_acc  = 1'b1;
                n_state      = ST_FB;
            end
            ST_FB: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = bhf_pkg::MUL_F2X;
                ctrl.ld_fb   = 1'b1;
                ctrl.ld_nf   = 1'b1;
                n_state      = ST_ADDD2;
            end
            ST_ADDD2: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = bhf_pkg::MUL_B1FB;
                ctrl.ld_ns   = 1'b1;
                ctrl.add_d2  = 1'b1;
                n_state      = ST_UPD1;
            end
            ST_UPD1: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = bhf_pkg::MUL_B2FB;
                ctrl.ld_d1   = 1'b1;
                n_state      = ST_UPD2;
            end
            ST_UPD2: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = bhf_pkg::MUL_GAIN;
                ctrl.ld_d2   = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                // hold here while the previous result is still waiting
                ctrl.ld_out = !i_out_busy;
                if (!i_out_busy) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_ctrl = ctrl;

endmodule

### hdl/biquad_highpass_filter.sv
// Top level of the biquad highpass filter with its datapath and configuration registers.
//
// Second-order IIR filter, transposed direct form II, fixed point.
// Input stream (i_s_*): one signed sample per request, sample_in in tdata low bits.
// Output stream (o_m_*): one filtered, gain-scaled, saturated sample per input.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index
//   (0..4 feed0, feed1, feed2, back1, back2 coefficients; 5 output gain).
//   Write only while the filter is idle; other indexes are ignored.
// Sequence: an accepted sample steps through states MF0, ACC, FB, ADDD2, UPD1, UPD2 and
//   OUT, which registers the result and raises o_m_tvalid. The single shared multiplier
//   computes six products in sequence; o_s_tready is high only when idle, after OUT.
// Stall: a finished sample waits in the output register; the next sample is
//   accepted and processed meanwhile, holding at its final step until the
//   waiting result is taken.
// Reset: delay state and coefficients clear, gain is set to 1.0, both
//   streams go idle.
module biquad_highpass_filter #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   i_s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    // master stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   o_m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [bhf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]          i_cfg_data
);

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int GW = COEF_FRAC_BITS + 1;
    localparam int PW = bhf_pkg::FB_BITS + CW;
    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

    // configuration registers
    logic signed [CW-1:0] r_f0, r_f1, r_f2, r_b1, r_b2;
    logic        [GW-1:0] r_gain;

    // datapath registers
    logic signed [SAMPLE_BITS-1:0]       r_x;
    logic signed [bhf_pkg::ACC_BITS-1:0] r_acc, r_ns, r_d1, r_d2;
    logic signed [bhf_pkg::FB_BITS-1:0]  r_fb;
    logic signed [bhf_pkg::NF_BITS-1:0]  r_nf;
    logic signed [SAMPLE_BITS-1:0]       r_out;
    logic                                r_out_valid, n_out_valid;

    bhf_pkg::t_ctrl                      ctrl;
    logic                                idle;
    logic                                s_acc;
    logic                                out_busy;
    logic signed [bhf_pkg::FB_BITS-1:0]  mul_a;
    logic signed [CW-1:0]                mul_b;
    logic signed [PW-1:0]                prod;
    logic signed [bhf_pkg::ACC_BITS-1:0] prod_sat;
    logic signed [bhf_pkg::NF_BITS-1:0]  alu_a, alu_b, alu_sum;
    logic                                alu_sub;
    logic signed [63:0]                  fb_round, out_round, out_clamp;
    logic signed [bhf_pkg::FB_BITS-1:0]  fb_next;
    logic signed [SAMPLE_BITS-1:0]       out_next;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_busy   = r_out_valid && !i_m_tready;
    assign o_s_tready = idle;

    // Sequencer
    bhf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_acc),
        .i_out_busy (out_busy),
        .o_idle     (idle),
        .o_ctrl     (ctrl)
    );

    // Multiplier operand select
    always_comb begin
        mul_a = bhf_pkg::FB_BITS'(r_x);
        mul_b = r_f0;
        unique case (ctrl.mul_sel)
            bhf_pkg::MUL_F0X:  begin mul_a = bhf_pkg::FB_BITS'(r_x); mul_b = r_f0; end
            bhf_pkg::MUL_F1X:  begin mul_a = bhf_pkg::FB_BITS'(r_x); mul_b = r_f1; end
            bhf_pkg::MUL_F2X:  begin mul_a = bhf_pkg::FB_BITS'(r_x); mul_b = r_f2; end
            bhf_pkg::MUL_B1FB: begin mul_a = r_fb; mul_b = r_b1; end
            bhf_pkg::MUL_B2FB: begin mul_a = r_fb; mul_b = r_b2; end
            bhf_pkg::MUL_GAIN: begin mul_a = r_fb; mul_b = $signed({1'b0, r_gain}); end
            default:           begin mul_a = bhf_pkg::FB_BITS'(r_x); mul_b = r_f0; end
        endcase
    end

    bhf_mult #(
        .A_W (bhf_pkg::FB_BITS),
        .B_W (CW)
    ) u_mult (
        .i_clk  (i_clk),
        .i_en   (ctrl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign prod_sat = bhf_pkg::sat_acc(64'(prod));

    // Shared adder: add or subtract the saturated product or the second delay
    always_comb begin
        alu_a   = bhf_pkg::NF_BITS'(r_d1);
        alu_b   = bhf_pkg::NF_BITS'(prod_sat);
        alu_sub = 1'b0;
        if (ctrl.add_d2) begin
            alu_a = r_nf;
            alu_b = bhf_pkg::NF_BITS'(r_d2);
        end else if (ctrl.ld_d1) begin
            alu_a   = r_nf;
            alu_sub = 1'b1;
        end else if (ctrl.ld_d2) begin
            alu_a   = bhf_pkg::NF_BITS'(r_ns);
            alu_sub = 1'b1;
        end
        alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    // Round half up and clamp for feedback and output
    always_comb begin
        fb_round  = (64'(r_acc) + HALF) >>> COEF_FRAC_BITS;
        fb_next   = bhf_pkg::sat_fb(fb_round);
        out_round = (64'(prod) + HALF) >>> COEF_FRAC_BITS;
        if (out_round > SMAX) out_clamp = SMAX;
        else if (out_round < SMIN) out_clamp = SMIN;
        else out_clamp = out_round;
        out_next  = out_clamp[SAMPLE_BITS-1:0];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0   <= '0;
            r_f1   <= '0;
            r_f2   <= '0;
            r_b1   <= '0;
            r_b2   <= '0;
            r_gain <= {1'b1, {COEF_FRAC_BITS{1'b0}}};
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bhf_pkg::REG_FEED0: r_f0   <= i_cfg_data;
                bhf_pkg::REG_FEED1: r_f1   <= i_cfg_data;
                bhf_pkg::REG_FEED2: r_f2   <= i_cfg_data;
                bhf_pkg::REG_BACK1: r_b1   <= i_cfg_data;
                bhf_pkg::REG_BACK2: r_b2   <= i_cfg_data;
                bhf_pkg::REG_GAIN:  r_gain <= i_cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // Delay state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            if (ctrl.ld_d1) r_d1 <= bhf_pkg::sat_acc(64'(alu_sum));
            if (ctrl.ld_d2) r_d2 <= bhf_pkg::sat_acc(64'(alu_sum));
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (s_acc)       r_x   <= $signed(i_s_tdata[SAMPLE_BITS-1:0]);
        if (ctrl.ld_acc) r_acc <= bhf_pkg::sat_acc(64'(alu_sum));
        if (ctrl.ld_fb)  r_fb  <= fb_next;
        if (ctrl.ld_nf)  r_nf  <= bhf_pkg::NF_BITS'(prod_sat);
        else if (ctrl.add_d2) r_nf <= alu_sum;
        if (ctrl.ld_ns)  r_ns  <= prod_sat;
        if (ctrl.ld_out) r_out <= out_next;
    end

    // Output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (ctrl.ld_out) n_out_valid = 1'b1;
        else if (i_m_tready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DW'($unsigned(r_out));

`ifndef SYNTHESIS
    // an accepted sample keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("input ready right after accepting a sample");

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.ld_out |-> !(r_out_valid && !i_m_tready))
        else $error("result register overwritten while stalled");

    // at most one adder or rounding destination per cycle
    a_one_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctrl.ld_acc, ctrl.ld_fb, ctrl.add_d2, ctrl.ld_d1, ctrl.ld_d2, ctrl.ld_out}))
        else $error("conflicting datapath loads");

    // delay state changes only while a sample is in flight
    a_delay_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idle |=> $stable(r_d1) && $stable(r_d2))
        else $error("delay state changed while idle");
`endif

endmodule

### dv/tb_top.sv
// Self-checking testbench for the biquad highpass filter: stream stimulus, predictor, checks.
`timescale 1ns / 100ps

package tb_biquad_pkg;

    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 16;
    localparam int COEF_W   = FRAC_W + 2;
    localparam int GAIN_W   = FRAC_W + 1;

    // Indexes past the last register; writes there must change nothing
    localparam logic [bhf_pkg::CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [bhf_pkg::CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    // Tracks the filter state and holds the output samples still owed by the block
    class biquad_book;
        logic signed [COEF_W-1:0]            feed0, feed1, feed2, back1, back2;
        logic        [GAIN_W-1:0]            gain;
        logic signed [bhf_pkg::ACC_BITS-1:0] delay_first_q, delay_second_q;
        logic        [SAMPLE_W-1:0]          expected_out[$];
        int                                  error_count;

        function new();
            feed0 = '0;
            feed1 = '0;
            feed2 = '0;
            back1 = '0;
            back2 = '0;
            gain  = GAIN_W'(1) << FRAC_W;
            delay_first_q  = '0;
            delay_second_q = '0;
            error_count    = 0;
        endfunction

        // One line per mismatch
        task report(string what);
            $display("ERROR @%0t: %s", $time, what);
            error_count++;
        endtask

        static function longint clamp(longint v, int w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Drop the fraction bits, rounding half up
        static function longint round_frac(longint v);
            return (v + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        endfunction

        function void write_reg(logic [bhf_pkg::CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                bhf_pkg::REG_FEED0: feed0 = data;
                bhf_pkg::REG_FEED1: feed1 = data;
                bhf_pkg::REG_FEED2: feed2 = data;
                bhf_pkg::REG_BACK1: back1 = data;
                bhf_pkg::REG_BACK2: back2 = data;
                bhf_pkg::REG_GAIN:  gain  = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // One transposed-DF2 step; returns the gain-scaled output sample
        function logic [SAMPLE_W-1:0] filter_step(logic signed [SAMPLE_W-1:0] x_in);
            longint x, acc, fb, nf, ns, y;
            x   = longint'(x_in);
            acc = clamp(clamp(longint'(feed0) * x, bhf_pkg::ACC_BITS)
                        + longint'(delay_first_q), bhf_pkg::ACC_BITS);
            fb  = clamp(round_frac(acc), bhf_pkg::FB_BITS);
            nf  = clamp(longint'(feed1) * x, bhf_pkg::ACC_BITS)
                - clamp(longint'(back1) * fb, bhf_pkg::ACC_BITS)
                + longint'(delay_second_q);
            ns  = clamp(longint'(feed2) * x, bhf_pkg::ACC_BITS)
                - clamp(longint'(back2) * fb, bhf_pkg::ACC_BITS);
            nf  = clamp(nf, bhf_pkg::ACC_BITS);
            ns  = clamp(ns, bhf_pkg::ACC_BITS);
            delay_first_q  = nf[bhf_pkg::ACC_BITS-1:0];
            delay_second_q = ns[bhf_pkg::ACC_BITS-1:0];
            y = clamp(round_frac(fb * longint'(gain)), SAMPLE_W);
            return y[SAMPLE_W-1:0];
        endfunction

        function void accept_sample(logic signed [SAMPLE_W-1:0] x);
            expected_out.push_back(filter_step(x));
        endfunction

        task check_output(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            if (expected_out.size() == 0) begin
                report($sformatf("output sample %0d with none outstanding", $signed(got)));
            end else begin
                want = expected_out.pop_front();
                if (got !== want)
                    report($sformatf("sample_out got %0d expected %0d",
                                     $signed(got), $signed(want)));
            end
        endtask
    endclass

endpackage

module tb_top;
    import tb_biquad_pkg::*;

    localparam int  LATENCY     = 7;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  RAND_PHASES = 10;
    localparam int  PHASE_ITEMS = 103;
    localparam int  HOLD_AT     = 600;   // output count that starts the long back-pressure
    localparam int  HOLD_CYCLES = 300;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;
    localparam logic [COEF_W-1:0]   COEF_MAX   = 18'h1FFFF;
    localparam logic [COEF_W-1:0]   COEF_MIN   = 18'h20000;
    localparam logic [COEF_W-1:0]   COEF_ONE   = 18'h10000;
    localparam logic [COEF_W-1:0]   COEF_HALF  = 18'h08000;
    localparam logic [COEF_W-1:0]   GAIN_MAX   = 18'h1FFFF;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [SAMPLE_W-1:0]           i_s_tdata;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [SAMPLE_W-1:0]           o_m_tdata;
    logic                          i_cfg_wr_en;
    logic [bhf_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [COEF_W-1:0]             i_cfg_data;

    biquad_book book = new();
    int         accepted_count = 0;
    int         taken_count    = 0;
    int         cycle_count    = 0;

    biquad_highpass_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // Output side: random back-pressure, one calm stretch, one long hold-off
    initial begin : output_sink
        int hold_left;
        bit held;
        hold_left  = 0;
        held       = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && taken_count >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else if (taken_count >= 300 && taken_count < 450) begin
                i_m_tready = 1'b1;
            end else begin
                i_m_tready = ($urandom_range(99) >= 8);
            end
        end
    end

    // Check every output request against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            book.check_output(o_m_tdata);
            taken_count++;
        end
    end

    // Offer one sample, idling at random first, and note it once accepted
    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        while (!(accepted_count >= 300 && accepted_count < 450)
               && $urandom_range(99) < 8) begin
            i_s_tvalid = 1'b0;
            i_s_tdata  = SAMPLE_W'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = x;
        do @(posedge i_clk); while (!o_s_tready);
        book.accept_sample(x);
        accepted_count++;
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [bhf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        book.write_reg(idx, data);
    endtask

    task automatic load_config(input logic [COEF_W-1:0] f0, f1, f2, b1, b2, g);
        cfg_write(bhf_pkg::REG_FEED0, f0);
        cfg_write(bhf_pkg::REG_FEED1, f1);
        cfg_write(bhf_pkg::REG_FEED2, f2);
        cfg_write(bhf_pkg::REG_BACK1, b1);
        cfg_write(bhf_pkg::REG_BACK2, b2);
        cfg_write(bhf_pkg::REG_GAIN,  g);
    endtask

    // Stop offering, let every owed output arrive, then let the pipe settle
    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (book.expected_out.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        logic [COEF_W-1:0] v;
        case ($urandom_range(3))
            0: v = COEF_MAX;
            1: v = COEF_MIN;
            2: begin
                v = COEF_W'($urandom_range(0, 65535));
                v = v - 18'd32768;
            end
            default: v = COEF_W'($urandom);
        endcase
        return v;
    endfunction

    // Upper data bit is junk for the gain register and must be dropped
    function automatic logic [COEF_W-1:0] pick_gain();
        logic [COEF_W-1:0] v;
        case ($urandom_range(3))
            0: v = '0;
            1: v = GAIN_MAX;
            default: v = COEF_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(9))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2, 3: begin
                v = SAMPLE_W'($urandom_range(0, 511));
                v = v - 24'd256;
            end
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset values: zero coefficients give silence
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        wait_drained();

        // Unity pass-through over the sample extremes
        load_config(COEF_ONE, '0, '0, '0, '0, COEF_ONE);
        send_sample('0);
        send_sample(24'd1);
        send_sample(-24'sd1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        wait_drained();

        // Half-step taps hit rounding ties; stray gain bit and spare indexes ignored
        load_config(COEF_HALF, '0, '0, '0, '0, 18'h30000);
        cfg_write(REG_SPARE6, '1);
        cfg_write(REG_SPARE7, '1);
        send_sample(24'd1);
        send_sample(-24'sd1);
        send_sample(24'd3);
        send_sample(-24'sd3);
        wait_drained();

        // Extreme taps: product and sum saturation, feedback clamp, output clamp
        load_config(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, GAIN_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(SAMPLE_MIN);
        wait_drained();

        // Zero gain while the state runs away
        load_config(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN, '0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'd1);
        wait_drained();

        // Random phases; every third one uses a stable highpass so the state stays live
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph % 3 == 0)
                load_config(18'd62259, -18'sd124518, 18'd62259, -18'sd124340, 18'd59305,
                            pick_gain());
            else
                load_config(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                            pick_gain());
            if ($urandom_range(1))
                cfg_write($urandom_range(1) ? REG_SPARE6 : REG_SPARE7, COEF_W'($urandom));
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(pick_sample());
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (book.expected_out.size() != 0)
            book.report($sformatf("%0d output samples never arrived",
                                  book.expected_out.size()));
        if (book.error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
